// ----- rtl/scst_pkg.sv -----
`default_nettype none

package scst_pkg;

  localparam int ADDR_W  = 32;
  localparam int FLAG_W  = 2;
  localparam int REQ_W   = 2;
  localparam int IDX_W   = 9;
  localparam int DEPTH_W = 9;
  localparam int STAT_W  = 3;

  localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RET  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    ST_PUSHED   = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_MATCHED  = 3'd3,
    ST_UNWOUND  = 3'd4,
    ST_REPLACED = 3'd5,
    ST_READ     = 3'd6
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] tgt;
    logic [ADDR_W-1:0] ret;
    logic [FLAG_W-1:0] kind;
  } frame_t;

endpackage

`default_nettype wire

// ----- rtl/scst_in_if.sv -----
`default_nettype none

interface scst_in_if;
  logic                         valid;
  logic                         ready;
  logic [scst_pkg::REQ_W-1:0]   req_type;
  logic [scst_pkg::ADDR_W-1:0]  src_addr;
  logic [scst_pkg::ADDR_W-1:0]  dest_addr;
  logic [scst_pkg::ADDR_W-1:0]  ret_addr;
  logic [scst_pkg::FLAG_W-1:0]  frame_flags;
  logic [scst_pkg::IDX_W-1:0]   read_index;

  modport source (
    output valid, req_type, src_addr, dest_addr, ret_addr, frame_flags, read_index,
    input  ready
  );
  modport sink (
    input  valid, req_type, src_addr, dest_addr, ret_addr, frame_flags, read_index,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/scst_out_if.sv -----
`default_nettype none

interface scst_out_if;
  logic                          valid;
  logic                          ready;
  logic [scst_pkg::STAT_W-1:0]   status;
  logic [scst_pkg::DEPTH_W-1:0]  depth;
  logic                          top_valid;
  logic [scst_pkg::ADDR_W-1:0]   top_return;
  logic [scst_pkg::ADDR_W-1:0]   entry_source;
  logic [scst_pkg::ADDR_W-1:0]   entry_target;
  logic [scst_pkg::ADDR_W-1:0]   entry_return;
  logic [scst_pkg::FLAG_W-1:0]   entry_flags;

  modport source (
    output valid, status, depth, top_valid, top_return,
           entry_source, entry_target, entry_return, entry_flags,
    input  ready
  );
  modport sink (
    input  valid, status, depth, top_valid, top_return,
           entry_source, entry_target, entry_return, entry_flags,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/scst_frame_mem.sv -----
`default_nettype none

module scst_frame_mem #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  wire                    clk,
  input  wire                    wr_en,
  input  wire [AW-1:0]           wr_addr,
  input  scst_pkg::frame_t       wr_data,
  input  wire                    rd_en,
  input  wire [AW-1:0]           rd_addr,
  output scst_pkg::frame_t       rd_data
);

  scst_pkg::frame_t mem [DEPTH];
  scst_pkg::frame_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/scst_slot_unit.sv -----
`default_nettype none

// Ring address: (base + pos) mod SLOTS, both operands already below SLOTS.
module scst_slot_unit #(
  parameter int SLOTS = 512,
  parameter int W     = 9
) (
  input  wire [W-1:0]  base,
  input  wire [W-1:0]  pos,
  output logic [W-1:0] slot
);

  localparam logic [W:0] SLOTS_X = (W+1)'(SLOTS);

  logic [W:0] sum;
  logic [W:0] wrapped;

  always_comb begin
    sum     = {1'b0, base} + {1'b0, pos};
    wrapped = sum - SLOTS_X;
    slot    = (sum >= SLOTS_X) ? wrapped[W-1:0] : sum[W-1:0];
  end

endmodule

`default_nettype wire

// ----- rtl/shadow_call_stack_tracker_unit.sv -----
// Shadow call stack tracker. Holds up to MAX_FRAMES call frames (source, target, return,
// kind) in a ring memory of MAX_FRAMES+1 slots with one write and one registered read port;
// a sequencer drives every slot address through one shared ring adder and every return
// compare through one comparator. A push checks for a full stack, dropping the oldest
// frame if so, and then writes; a read fetches the indexed frame unless the index is at
// or beyond the depth; an unused request code or a return on an empty stack goes straight
// to the result; any other return pops and compares the top frame, searches downward if
// it misses (one memory read then one compare per frame), then unwinds or replaces.
// A new request is taken once the sequencer is back in idle; one result waiting in the
// output register does not hold off the next request, but a second finished result waits
// in the sequencer until the first is taken. No clearing pass after reset.
`default_nettype none

module shadow_call_stack_tracker_unit #(
  parameter int MAX_FRAMES = 511
) (
  input  wire          clk,
  input  wire          rst_n,
  scst_in_if.sink      in_chan,
  scst_out_if.source   out_chan
);

  localparam int SLOTS = MAX_FRAMES + 1;
  localparam int W     = $clog2(SLOTS);
  localparam int XW    = (W > scst_pkg::IDX_W) ? W : scst_pkg::IDX_W;
  localparam logic [W-1:0] MAX_C = W'(MAX_FRAMES);
  localparam logic [W-1:0] ONE_C = W'(1);
  localparam logic [W:0]   SLOTS_C = (W+1)'(SLOTS);

  typedef enum logic [3:0] {
    S_IDLE, S_DROP, S_PUSH, S_POPRD, S_POPCHK, S_SCANRD, S_SCANCMP,
    S_REPL, S_READRD, S_READCAP, S_TOPRD, S_TOPCAP, S_DONE
  } state_t;

  state_t state_r;
  logic [W-1:0] count_r, oldest_r, scan_r;
  logic [scst_pkg::ADDR_W-1:0] src_r, dst_r, ret_r, popped_r, top_ret_r;
  logic [scst_pkg::FLAG_W-1:0] kind_r;
  logic [scst_pkg::IDX_W-1:0]  idx_r;
  scst_pkg::status_t st_r;
  scst_pkg::frame_t  ent_r;

  logic                          out_valid_r;
  scst_pkg::status_t             out_st_r;
  logic [scst_pkg::DEPTH_W-1:0]  out_depth_r;
  logic                          out_top_v_r;
  logic [scst_pkg::ADDR_W-1:0]   out_top_r;
  scst_pkg::frame_t              out_ent_r;

  logic [W-1:0] pos, slot;
  logic wr_en, rd_en, ret_match, in_acc, load;
  scst_pkg::frame_t wr_data, rd_data;
  logic [XW-1:0] idx_x, cnt_x;

  scst_slot_unit #(.SLOTS(SLOTS), .W(W)) u_slot (
    .base(oldest_r), .pos(pos), .slot(slot)
  );

  scst_frame_mem #(.DEPTH(SLOTS), .AW(W)) u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr(slot), .wr_data(wr_data),
    .rd_en(rd_en), .rd_addr(slot), .rd_data(rd_data)
  );

  assign idx_x     = XW'(idx_r);
  assign cnt_x     = XW'(count_r);
  assign ret_match = (rd_data.ret == dst_r);
  assign in_acc    = in_chan.valid && in_chan.ready;
  assign load      = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  // Ring position requested from the shared adder in each step.
  always_comb begin
    pos     = '0;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    wr_data = '{src: src_r, tgt: dst_r, ret: ret_r, kind: kind_r};
    case (state_r)
      S_DROP:   pos = ONE_C;
      S_PUSH: begin
        pos   = count_r;
        wr_en = 1'b1;
      end
      S_POPRD: begin
        pos   = count_r - ONE_C;
        rd_en = 1'b1;
      end
      S_SCANRD: begin
        pos   = scan_r;
        rd_en = 1'b1;
      end
      S_REPL: begin
        pos     = count_r;
        wr_en   = 1'b1;
        wr_data = '{src: popped_r, tgt: dst_r, ret: popped_r, kind: '0};
      end
      S_READRD: begin
        pos   = idx_x[W-1:0];
        rd_en = (idx_x < cnt_x);
      end
      S_TOPRD: begin
        pos   = count_r - ONE_C;
        rd_en = (count_r != '0);
      end
      default: pos = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      oldest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            src_r  <= in_chan.src_addr;
            dst_r  <= in_chan.dest_addr;
            ret_r  <= in_chan.ret_addr;
            kind_r <= in_chan.frame_flags;
            idx_r  <= in_chan.read_index;
            ent_r  <= '0;
            case (in_chan.req_type)
              scst_pkg::REQ_PUSH: state_r <= S_DROP;
              scst_pkg::REQ_RET: begin
                if (count_r == '0) begin
                  st_r    <= scst_pkg::ST_EMPTY;
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_POPRD;
                end
              end
              scst_pkg::REQ_READ: begin
                st_r    <= scst_pkg::ST_READ;
                state_r <= S_READRD;
              end
              default: begin
                st_r    <= scst_pkg::ST_READ;
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_DROP: begin
          if (count_r == MAX_C) begin
            oldest_r <= slot;
            count_r  <= count_r - ONE_C;
            st_r     <= scst_pkg::ST_DROPPED;
          end else begin
            st_r     <= scst_pkg::ST_PUSHED;
          end
          state_r <= S_PUSH;
        end
        S_PUSH: begin
          count_r   <= count_r + ONE_C;
          top_ret_r <= ret_r;
          state_r   <= S_DONE;
        end
        S_POPRD: begin
          count_r <= count_r - ONE_C;
          state_r <= S_POPCHK;
        end
        S_POPCHK: begin
          popped_r <= rd_data.ret;
          if (count_r == '0 || ret_match) begin
            st_r    <= scst_pkg::ST_MATCHED;
            state_r <= S_TOPRD;
          end else begin
            scan_r  <= count_r - ONE_C;
            state_r <= S_SCANRD;
          end
        end
        S_SCANRD: state_r <= S_SCANCMP;
        S_SCANCMP: begin
          if (ret_match) begin
            count_r <= scan_r;
            st_r    <= scst_pkg::ST_UNWOUND;
            state_r <= S_TOPRD;
          end else if (scan_r == '0) begin
            state_r <= S_REPL;
          end else begin
            scan_r  <= scan_r - ONE_C;
            state_r <= S_SCANRD;
          end
        end
        S_REPL: begin
          count_r   <= count_r + ONE_C;
          top_ret_r <= popped_r;
          st_r      <= scst_pkg::ST_REPLACED;
          state_r   <= S_DONE;
        end
        S_READRD: begin
          state_r <= (idx_x < cnt_x) ? S_READCAP : S_DONE;
        end
        S_READCAP: begin
          ent_r   <= rd_data;
          state_r <= S_DONE;
        end
        S_TOPRD: begin
          state_r <= (count_r != '0) ? S_TOPCAP : S_DONE;
        end
        S_TOPCAP: begin
          top_ret_r <= rd_data.ret;
          state_r   <= S_DONE;
        end
        S_DONE: begin
          if (load) begin
            out_st_r    <= st_r;
            out_depth_r <= cnt_x[scst_pkg::DEPTH_W-1:0];
            out_top_v_r <= (count_r != '0);
            out_top_r   <= (count_r != '0) ? top_ret_r : '0;
            out_ent_r   <= ent_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_chan.ready         = (state_r == S_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_st_r;
  assign out_chan.depth        = out_depth_r;
  assign out_chan.top_valid    = out_top_v_r;
  assign out_chan.top_return   = out_top_r;
  assign out_chan.entry_source = out_ent_r.src;
  assign out_chan.entry_target = out_ent_r.tgt;
  assign out_chan.entry_return = out_ent_r.ret;
  assign out_chan.entry_flags  = out_ent_r.kind;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_C)
    else $error("frame count above limit");

  a_oldest_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, oldest_r} < SLOTS_C)
    else $error("oldest slot outside ring");

  a_scan_below_top: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCANRD || state_r == S_SCANCMP) |-> (scan_r < count_r))
    else $error("search index at or above top");

  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (load && st_r == scst_pkg::ST_DROPPED) |-> (count_r == MAX_C))
    else $error("drop reported without full stack");

  a_empty_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (load && st_r == scst_pkg::ST_EMPTY) |=> (out_depth_r == '0 && !out_top_v_r))
    else $error("empty return reported with frames held");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int STACK_LIMIT = 511;
  localparam int SLOT_COUNT = STACK_LIMIT + 1;
  localparam logic [scst_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int LONG_HOLD = 300;
  localparam int TIMEOUT_NS = 80_000_000;

  typedef struct packed {
    logic [scst_pkg::REQ_W-1:0]  kind;
    logic [scst_pkg::ADDR_W-1:0] src;
    logic [scst_pkg::ADDR_W-1:0] tgt;
    logic [scst_pkg::ADDR_W-1:0] ret;
    logic [scst_pkg::FLAG_W-1:0] flags;
    logic [scst_pkg::IDX_W-1:0]  index;
  } call_req_t;

  typedef struct packed {
    scst_pkg::status_t            status;
    logic [scst_pkg::DEPTH_W-1:0] depth;
    logic                         top_valid;
    logic [scst_pkg::ADDR_W-1:0]  top_return;
    scst_pkg::frame_t             entry;
  } stack_report_t;

  typedef struct {
    call_req_t     rq;
    bit            typed_in;
    stack_report_t want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  scst_in_if  call_bus ();
  scst_out_if report_bus ();

  shadow_call_stack_tracker_unit #(.MAX_FRAMES(STACK_LIMIT)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (call_bus),
    .out_chan (report_bus)
  );

  always #6 clk = ~clk;

  scst_pkg::frame_t shadow_frames [SLOT_COUNT];
  int               shadow_base = 0;
  int               shadow_depth = 0;
  stack_report_t    awaited_reports [$];
  script_row_t      script [$];
  int               mismatch_count = 0;
  int               sent_count = 0;
  int               got_count = 0;
  bit               tx_burst = 1'b0;
  bit               rx_burst = 1'b0;

  function automatic int ring_slot(int pos);
    return (shadow_base + pos) % SLOT_COUNT;
  endfunction

  function automatic scst_pkg::status_t shadow_push(scst_pkg::frame_t f);
    scst_pkg::status_t st;
    st = scst_pkg::ST_PUSHED;
    if (shadow_depth >= STACK_LIMIT) begin
      shadow_base = ring_slot(1);
      shadow_depth--;
      st = scst_pkg::ST_DROPPED;
    end
    shadow_frames[ring_slot(shadow_depth)] = f;
    shadow_depth++;
    return st;
  endfunction

  function automatic scst_pkg::status_t shadow_return(logic [scst_pkg::ADDR_W-1:0] dest);
    logic [scst_pkg::ADDR_W-1:0] popped;
    if (shadow_depth == 0) return scst_pkg::ST_EMPTY;
    popped = shadow_frames[ring_slot(shadow_depth - 1)].ret;
    shadow_depth--;
    if (shadow_depth == 0 || dest == popped) return scst_pkg::ST_MATCHED;
    // first hit from the top down cuts that frame and everything above it
    for (int i = shadow_depth; i > 0; i--) begin
      if (shadow_frames[ring_slot(i - 1)].ret == dest) begin
        shadow_depth = i - 1;
        return scst_pkg::ST_UNWOUND;
      end
    end
    void'(shadow_push(scst_pkg::frame_t'{src: popped, tgt: dest, ret: popped, kind: '0}));
    return scst_pkg::ST_REPLACED;
  endfunction

  function automatic stack_report_t shadow_apply(call_req_t rq);
    stack_report_t rep;
    rep = '0;
    case (rq.kind)
      scst_pkg::REQ_PUSH:
        rep.status = shadow_push(scst_pkg::frame_t'{src: rq.src, tgt: rq.tgt, ret: rq.ret,
                                                    kind: rq.flags});
      scst_pkg::REQ_RET:  rep.status = shadow_return(rq.tgt);
      default: begin
        rep.status = scst_pkg::ST_READ;
        if (rq.kind == scst_pkg::REQ_READ && int'(rq.index) < shadow_depth)
          rep.entry = shadow_frames[ring_slot(int'(rq.index))];
      end
    endcase
    rep.depth = scst_pkg::DEPTH_W'(shadow_depth);
    rep.top_valid = (shadow_depth > 0);
    if (shadow_depth > 0) rep.top_return = shadow_frames[ring_slot(shadow_depth - 1)].ret;
    return rep;
  endfunction

  function automatic call_req_t mk_req(logic [scst_pkg::REQ_W-1:0] kind,
                                       logic [scst_pkg::ADDR_W-1:0] src,
                                       logic [scst_pkg::ADDR_W-1:0] tgt,
                                       logic [scst_pkg::ADDR_W-1:0] ret,
                                       logic [scst_pkg::FLAG_W-1:0] flags,
                                       logic [scst_pkg::IDX_W-1:0] index);
    call_req_t rq;
    rq.kind = kind;
    rq.src = src;
    rq.tgt = tgt;
    rq.ret = ret;
    rq.flags = flags;
    rq.index = index;
    return rq;
  endfunction

  function automatic stack_report_t mk_report(scst_pkg::status_t st, int dep,
                                              logic [scst_pkg::ADDR_W-1:0] top,
                                              scst_pkg::frame_t e);
    stack_report_t rep;
    rep.status = st;
    rep.depth = scst_pkg::DEPTH_W'(dep);
    rep.top_valid = (dep != 0);
    rep.top_return = top;
    rep.entry = e;
    return rep;
  endfunction

  function automatic void add_row(call_req_t rq, bit typed_in, stack_report_t want);
    script_row_t row;
    row.rq = rq;
    row.typed_in = typed_in;
    row.want = want;
    script.insert(script.size(), row);
  endfunction

  // half the addresses come from a small pool so return addresses repeat
  function automatic logic [scst_pkg::ADDR_W-1:0] pick_address();
    if ($urandom_range(0, 1) == 1) return $urandom;
    return 32'h0000_8000 + ($urandom_range(0, 31) << 2);
  endfunction

  // mostly well-formed call/return traffic: returns usually go to the top frame
  function automatic call_req_t draw_request();
    int        roll;
    int        sub;
    call_req_t rq;
    roll = $urandom_range(0, 99);
    sub = $urandom_range(0, 99);
    rq = mk_req(scst_pkg::REQ_PUSH, $urandom, $urandom, pick_address(),
                scst_pkg::FLAG_W'($urandom_range(0, 3)),
                scst_pkg::IDX_W'($urandom_range(0, 511)));
    if (roll < 45) return rq;
    if (roll < 80) begin
      rq.kind = scst_pkg::REQ_RET;
      if (shadow_depth > 0 && sub < 70)
        rq.tgt = shadow_frames[ring_slot(shadow_depth - 1)].ret;
      else if (shadow_depth > 0 && sub < 88)
        rq.tgt = shadow_frames[ring_slot($urandom_range(0, shadow_depth - 1))].ret;
      else
        rq.tgt = pick_address();
      return rq;
    end
    if (roll < 95) begin
      rq.kind = scst_pkg::REQ_READ;
      if (shadow_depth > 0 && sub < 85)
        rq.index = scst_pkg::IDX_W'($urandom_range(0, shadow_depth - 1));
      return rq;
    end
    rq.kind = REQ_UNUSED;
    return rq;
  endfunction

  task automatic offer_request(input call_req_t rq, input bit typed_in,
                               input stack_report_t want);
    int            gap;
    stack_report_t predicted;
    if (sent_count % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
    gap = tx_burst ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      call_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    call_bus.req_type    <= rq.kind;
    call_bus.src_addr    <= rq.src;
    call_bus.dest_addr   <= rq.tgt;
    call_bus.ret_addr    <= rq.ret;
    call_bus.frame_flags <= rq.flags;
    call_bus.read_index  <= rq.index;
    call_bus.valid       <= 1'b1;
    do @(posedge clk); while (call_bus.ready !== 1'b1);
    predicted = shadow_apply(rq);
    if (typed_in) predicted = want;
    awaited_reports.insert(awaited_reports.size(), predicted);
    sent_count++;
  endtask

  task automatic compare_field(input string name, input logic [scst_pkg::ADDR_W-1:0] want,
                               input logic [scst_pkg::ADDR_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // result side
  initial begin
    int            hold;
    stack_report_t got;
    stack_report_t want;
    report_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (got_count % 50 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      if (got_count == 200 || got_count == 800) hold = LONG_HOLD;
      else hold = rx_burst ? 0 : $urandom_range(0, 6);
      if (hold > 0) begin
        @(negedge clk) report_bus.ready <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk) report_bus.ready <= 1'b1;
      do @(posedge clk); while (report_bus.valid !== 1'b1);
      got.status     = scst_pkg::status_t'(report_bus.status);
      got.depth      = report_bus.depth;
      got.top_valid  = report_bus.top_valid;
      got.top_return = report_bus.top_return;
      got.entry.src  = report_bus.entry_source;
      got.entry.tgt  = report_bus.entry_target;
      got.entry.ret  = report_bus.entry_return;
      got.entry.kind = report_bus.entry_flags;
      if (awaited_reports.size() == 0) begin
        $display("%0t: unexpected result, status %0d depth %0d", $time, got.status, got.depth);
        mismatch_count++;
      end else begin
        want = awaited_reports[0];
        awaited_reports.delete(0);
        compare_field("status", scst_pkg::ADDR_W'(want.status), scst_pkg::ADDR_W'(got.status));
        compare_field("depth", scst_pkg::ADDR_W'(want.depth), scst_pkg::ADDR_W'(got.depth));
        compare_field("top_valid", scst_pkg::ADDR_W'(want.top_valid),
                      scst_pkg::ADDR_W'(got.top_valid));
        compare_field("top_return", want.top_return, got.top_return);
        compare_field("entry_source", want.entry.src, got.entry.src);
        compare_field("entry_target", want.entry.tgt, got.entry.tgt);
        compare_field("entry_return", want.entry.ret, got.entry.ret);
        compare_field("entry_flags", scst_pkg::ADDR_W'(want.entry.kind),
                      scst_pkg::ADDR_W'(got.entry.kind));
      end
      got_count++;
    end
  end

  // request side
  initial begin
    call_bus.valid       <= 1'b0;
    call_bus.req_type    <= '0;
    call_bus.src_addr    <= '0;
    call_bus.dest_addr   <= '0;
    call_bus.ret_addr    <= '0;
    call_bus.frame_flags <= '0;
    call_bus.read_index  <= '0;

    add_row(mk_req(scst_pkg::REQ_RET, 0, 0, 0, 0, 0), 1'b1,
            mk_report(scst_pkg::ST_EMPTY, 0, 0, '0));
    add_row(mk_req(scst_pkg::REQ_READ, 0, 0, 0, 0, 0), 1'b1,
            mk_report(scst_pkg::ST_READ, 0, 0, '0));
    add_row(mk_req(REQ_UNUSED, '1, '1, '1, 2'd3, 9'd511), 1'b1,
            mk_report(scst_pkg::ST_READ, 0, 0, '0));
    add_row(mk_req(scst_pkg::REQ_PUSH, 32'hFFFF_FFFF, 0, 32'h0000_1000, 2'd3, 0), 1'b1,
            mk_report(scst_pkg::ST_PUSHED, 1, 32'h0000_1000, '0));
    add_row(mk_req(scst_pkg::REQ_READ, 0, 0, 0, 0, 0), 1'b1,
            mk_report(scst_pkg::ST_READ, 1, 32'h0000_1000,
                      '{src: 32'hFFFF_FFFF, tgt: 32'h0, ret: 32'h0000_1000, kind: 2'd3}));
    add_row(mk_req(scst_pkg::REQ_READ, 0, 0, 0, 0, 9'd511), 1'b1,
            mk_report(scst_pkg::ST_READ, 1, 32'h0000_1000, '0));
    // return that empties the stack matches whatever the destination
    add_row(mk_req(scst_pkg::REQ_RET, 0, 32'hFFFF_FFFF, 0, 0, 0), 1'b1,
            mk_report(scst_pkg::ST_MATCHED, 0, 0, '0));
    add_row(mk_req(scst_pkg::REQ_PUSH, 0, 32'hFFFF_FFFF, 32'h0000_2000, 2'd0, 0), 1'b1,
            mk_report(scst_pkg::ST_PUSHED, 1, 32'h0000_2000, '0));
    add_row(mk_req(scst_pkg::REQ_PUSH, 1, 2, 32'h0000_3000, 2'd1, 0), 1'b1,
            mk_report(scst_pkg::ST_PUSHED, 2, 32'h0000_3000, '0));
    add_row(mk_req(scst_pkg::REQ_PUSH, 3, 4, 32'h0000_4000, 2'd2, 0), 1'b1,
            mk_report(scst_pkg::ST_PUSHED, 3, 32'h0000_4000, '0));
    add_row(mk_req(scst_pkg::REQ_RET, 0, 32'h0000_4000, 0, 0, 0), 1'b1,
            mk_report(scst_pkg::ST_MATCHED, 2, 32'h0000_3000, '0));
    add_row(mk_req(scst_pkg::REQ_PUSH, 5, 6, 32'h0000_5000, 2'd3, 0), 1'b1,
            mk_report(scst_pkg::ST_PUSHED, 3, 32'h0000_5000, '0));
    // unwind down to the bottom frame leaves nothing
    add_row(mk_req(scst_pkg::REQ_RET, 0, 32'h0000_2000, 0, 0, 0), 1'b1,
            mk_report(scst_pkg::ST_UNWOUND, 0, 0, '0));
    add_row(mk_req(scst_pkg::REQ_PUSH, 7, 8, 32'h0000_2000, 2'd0, 0), 1'b0, '0);
    add_row(mk_req(scst_pkg::REQ_PUSH, 9, 10, 32'h0000_3000, 2'd1, 0), 1'b0, '0);
    add_row(mk_req(scst_pkg::REQ_PUSH, 11, 12, 32'h0000_4000, 2'd2, 0), 1'b0, '0);
    add_row(mk_req(scst_pkg::REQ_RET, 0, 32'hFFFF_FFFF, 0, 0, 0), 1'b0, '0);
    add_row(mk_req(scst_pkg::REQ_READ, 0, 0, 0, 0, 9'd2), 1'b0, '0);
    add_row(mk_req(scst_pkg::REQ_READ, 0, 0, 0, 0, 9'd3), 1'b0, '0);
    add_row(mk_req(scst_pkg::REQ_RET, 0, 32'h0000_3000, 0, 0, 0), 1'b0, '0);
    add_row(mk_req(scst_pkg::REQ_PUSH, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 2'd3, 0),
            1'b0, '0);
    add_row(mk_req(scst_pkg::REQ_RET, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_req(scst_pkg::REQ_READ, 0, 0, 0, 0, 9'd1), 1'b0, '0);
    add_row(mk_req(REQ_UNUSED, 0, 0, 0, 0, 0), 1'b0, '0);

    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (script[k]) offer_request(script[k].rq, script[k].typed_in, script[k].want);

    repeat (250) offer_request(draw_request(), 1'b0, '0);

    // let every outstanding request report before going on
    @(negedge clk) call_bus.valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);

    // fill to the limit, then overflow so the oldest frames get dropped
    while (shadow_depth < STACK_LIMIT) begin
      if ($urandom_range(0, 99) < 85)
        offer_request(mk_req(scst_pkg::REQ_PUSH, $urandom, $urandom, pick_address(),
                             scst_pkg::FLAG_W'($urandom_range(0, 3)),
                             scst_pkg::IDX_W'($urandom_range(0, 511))),
                      1'b0, '0);
      else
        offer_request(mk_req(scst_pkg::REQ_READ, 0, 0, 0, 0,
                             scst_pkg::IDX_W'($urandom_range(0, STACK_LIMIT))),
                      1'b0, '0);
    end
    repeat (12)
      offer_request(mk_req(scst_pkg::REQ_PUSH, $urandom, $urandom, $urandom,
                           scst_pkg::FLAG_W'($urandom_range(0, 3)), 0), 1'b0, '0);
    offer_request(mk_req(scst_pkg::REQ_READ, 0, 0, 0, 0, 9'd0), 1'b0, '0);
    offer_request(mk_req(scst_pkg::REQ_READ, 0, 0, 0, 0, 9'd510), 1'b0, '0);
    offer_request(mk_req(scst_pkg::REQ_READ, 0, 0, 0, 0, 9'd511), 1'b0, '0);
    // deep search on a full stack
    offer_request(mk_req(scst_pkg::REQ_RET, 0, 32'hFFFF_FFF0, 0, 0, 0), 1'b0, '0);
    offer_request(mk_req(scst_pkg::REQ_RET, 0, shadow_frames[ring_slot(0)].ret, 0, 0, 0),
                  1'b0, '0);

    repeat (150) offer_request(draw_request(), 1'b0, '0);

    @(negedge clk) call_bus.valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/scst_pkg.sv
rtl/scst_in_if.sv
rtl/scst_out_if.sv
rtl/scst_frame_mem.sv
rtl/scst_slot_unit.sv
rtl/shadow_call_stack_tracker_unit.sv
test/tb_top.sv
